// File: sv/cmmd_pkg.sv
`timescale 1ns / 1ps
package cmmd_pkg;

  // field and state widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned SpcW    = 25;
  localparam int unsigned ColW    = 13;
  localparam int unsigned HalfW   = 11;
  localparam int unsigned OrgW    = 12;
  localparam int unsigned XW      = 13;
  localparam int unsigned YW      = 14;
  localparam int unsigned IdxW    = 24;
  localparam int unsigned AccW    = 40;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = SpcW;

  // |h * v| needs at most 27 bits (2047 * 32768)
  localparam int unsigned ProdW   = 27;
  localparam int unsigned MagW    = SampleW + 1;
  localparam int unsigned QuotW   = 12;

  localparam logic [ColW-1:0]    MaxColumns  = 13'd4096;
  localparam logic [SpcW-1:0]    StepMin     = 25'h001_0000;
  localparam logic [AccW-1:0]    RoundHalf   = 40'h00_0000_8000;
  localparam logic [15:0]        SampleMaxU  = 16'd32767;
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  // configuration register reset values
  localparam logic [SpcW-1:0]  SpcReset      = 25'h001_0000;
  localparam logic [ColW-1:0]  ColCountReset = 13'd1024;
  localparam logic [HalfW-1:0] HalfReset     = 11'd128;

  typedef enum logic [CfgIdxW-1:0] {
    RegSamplesPerColumn = 3'd0,
    RegColumnCount      = 3'd1,
    RegHalfHeight       = 3'd2,
    RegXOrigin          = 3'd3,
    RegYOrigin          = 3'd4
  } cfg_reg_e;

endpackage

// File: sv/column_min_max_decimator_core.sv
`timescale 1ns / 1ps
// a sample that closes a column shows its result transaction on the output after passing
//   stage a, stage b and the output stage (state update, multiply, divide-by-32767 and add)
// throughput: one sample per cycle; input stalls only when the 3-stage result pipe is full
//   and the output is stalled
// reset: asynchronous, active low; registers take their documented reset values and the
//   block waits for a sample with frame_start set before producing anything
module column_min_max_decimator_core import cmmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // sample channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_value_i,
  input  logic                      frame_start_i,
  // column result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [XW-1:0]             column_x_o,
  output logic signed [YW-1:0]      y_for_min_o,
  output logic signed [YW-1:0]      y_for_max_o,
  output logic                      last_column_o,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SpcW-1:0]  spc_q;
  logic [ColW-1:0]  col_count_q;
  logic [HalfW-1:0] half_q;
  logic [OrgW-1:0]  x_org_q;
  logic [OrgW-1:0]  y_org_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q       <= SpcReset;
      col_count_q <= ColCountReset;
      half_q      <= HalfReset;
      x_org_q     <= '0;
      y_org_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegSamplesPerColumn: spc_q       <= cfg_data_i[SpcW-1:0];
        RegColumnCount:      col_count_q <= cfg_data_i[ColW-1:0];
        RegHalfHeight:       half_q      <= cfg_data_i[HalfW-1:0];
        RegXOrigin:          x_org_q     <= cfg_data_i[OrgW-1:0];
        RegYOrigin:          y_org_q     <= cfg_data_i[OrgW-1:0];
        default: ;  // unused register indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: each stage moves when the one after it has room
  // ---------------------------------------------------------------------------
  logic valid_a_q, valid_b_q, out_valid_q;
  logic out_ready, b_ready, a_ready, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_ready    = !valid_b_q || out_ready;
  assign a_ready    = !valid_a_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_accept  = in_valid_i && a_ready;

  // ---------------------------------------------------------------------------
  // column tracking state
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [ColW-1:0]           col_q, col_d;
  logic [AccW-1:0]           acc_q, acc_d;
  logic signed [SampleW-1:0] min_q, min_d;
  logic signed [SampleW-1:0] max_q, max_d;
  logic                      done_q, done_d;

  // values after an optional frame restart
  logic [IdxW-1:0]           idx_e;
  logic [ColW-1:0]           col_e;
  logic [AccW-1:0]           acc_e;
  logic signed [SampleW-1:0] min_e, max_e, min_n, max_n;
  logic                      done_e;

  logic [SpcW-1:0] step;
  logic [AccW-1:0] acc_round;
  logic [IdxW-1:0] end_idx;
  logic [ColW-1:0] col_limit;
  logic            col_close, col_last, emit;

  // samples per column below one is treated as one
  assign step = (spc_q < StepMin) ? StepMin : spc_q;

  // zero or an oversized count means the full column range
  assign col_limit = (col_count_q == '0 || col_count_q > MaxColumns) ? MaxColumns : col_count_q;

  always_comb begin
    if (frame_start_i) begin
      idx_e  = '0;
      col_e  = '0;
      acc_e  = AccW'(step);
      min_e  = SampleMax;
      max_e  = SampleMin;
      done_e = 1'b0;
    end else begin
      idx_e  = idx_q;
      col_e  = col_q;
      acc_e  = acc_q;
      min_e  = min_q;
      max_e  = max_q;
      done_e = done_q;
    end

    min_n = (sample_value_i < min_e) ? sample_value_i : min_e;
    max_n = (sample_value_i > max_e) ? sample_value_i : max_e;

    // column end index: accumulator rounded half up, integer part, low 24 bits
    acc_round = acc_e + RoundHalf;
    end_idx   = acc_round[AccW-1:16];
    col_close = (idx_e == end_idx);
    col_last  = ({1'b0, col_e} + 14'd1) >= {1'b0, col_limit};
    emit      = !done_e && col_close;

    idx_d  = idx_e;
    col_d  = col_e;
    acc_d  = acc_e;
    min_d  = min_e;
    max_d  = max_e;
    done_d = done_e;

    if (!done_e) begin
      idx_d = idx_e + IdxW'(1);
      min_d = min_n;
      max_d = max_n;
      if (col_close) begin
        if (col_last) begin
          done_d = 1'b1;
        end else begin
          col_d = col_e + ColW'(1);
          acc_d = acc_e + AccW'(step);
          // boundary sample opens the next column too
          min_d = sample_value_i;
          max_d = sample_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      col_q  <= '0;
      acc_q  <= AccW'(SpcReset);
      min_q  <= SampleMax;
      max_q  <= SampleMin;
      done_q <= 1'b1;
    end else if (in_accept) begin
      idx_q  <= idx_d;
      col_q  <= col_d;
      acc_q  <= acc_d;
      min_q  <= min_d;
      max_q  <= max_d;
      done_q <= done_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: closed column, with the scaling settings captured alongside
  // ---------------------------------------------------------------------------
  logic [XW-1:0]             x_a_q;
  logic signed [SampleW-1:0] min_a_q, max_a_q;
  logic                      last_a_q;
  logic [HalfW-1:0]          half_a_q;
  logic [OrgW-1:0]           y_org_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (a_ready) begin
      valid_a_q <= in_accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      x_a_q     <= XW'(x_org_q) + XW'(col_e);
      min_a_q   <= min_n;
      max_a_q   <= max_n;
      last_a_q  <= col_last;
      half_a_q  <= half_q;
      y_org_a_q <= y_org_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: |half * v| for both extremes
  // ---------------------------------------------------------------------------
  logic [MagW-1:0]  mag_min, mag_max;
  logic [ProdW-1:0] prod_min, prod_max;

  logic [XW-1:0]    x_b_q;
  logic [ProdW-1:0] prod_min_b_q, prod_max_b_q;
  logic             neg_min_b_q, neg_max_b_q;
  logic             last_b_q;
  logic [YW-1:0]    base_b_q;

  function automatic logic [MagW-1:0] magnitude(logic signed [SampleW-1:0] v);
    logic [MagW-1:0] ext;
    ext = MagW'(unsigned'(v)) | (v[SampleW-1] ? {1'b1, {SampleW{1'b0}}} : '0);
    return ext[MagW-1] ? (~ext + MagW'(1)) : ext;
  endfunction

  assign mag_min  = magnitude(min_a_q);
  assign mag_max  = magnitude(max_a_q);
  assign prod_min = ProdW'(28'(mag_min) * 28'(half_a_q));
  assign prod_max = ProdW'(28'(mag_max) * 28'(half_a_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (b_ready) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && valid_a_q) begin
      x_b_q        <= x_a_q;
      prod_min_b_q <= prod_min;
      prod_max_b_q <= prod_max;
      neg_min_b_q  <= min_a_q[SampleW-1];
      neg_max_b_q  <= max_a_q[SampleW-1];
      last_b_q     <= last_a_q;
      base_b_q     <= YW'(y_org_a_q) + YW'(half_a_q);
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: divide by 32767 toward zero and offset from y_origin + half
  // ---------------------------------------------------------------------------
  // p / 32767: take p >> 15, then one correction since the remainder stays
  // below twice the divisor
  function automatic logic [QuotW-1:0] div_smax(logic [ProdW-1:0] p);
    logic [QuotW-1:0] q0;
    logic [15:0]      rem;
    q0  = p[ProdW-1:15];
    rem = {1'b0, p[14:0]} + 16'(q0);
    return (rem >= SampleMaxU) ? q0 + QuotW'(1) : q0;
  endfunction

  function automatic logic [YW-1:0] y_pos(logic [YW-1:0] base, logic [ProdW-1:0] p,
                                          logic neg);
    logic [YW-1:0] q;
    q = YW'(div_smax(p));
    return neg ? base + q : base - q;
  endfunction

  logic [XW-1:0]          x_q;
  logic signed [YW-1:0]   y_min_q, y_max_q;
  logic                   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && valid_b_q) begin
      x_q     <= x_b_q;
      y_min_q <= signed'(y_pos(base_b_q, prod_min_b_q, neg_min_b_q));
      y_max_q <= signed'(y_pos(base_b_q, prod_max_b_q, neg_max_b_q));
      last_q  <= last_b_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_x_o    = x_q;
  assign y_for_min_o   = y_min_q;
  assign y_for_max_o   = y_max_q;
  assign last_column_o = last_q;

endmodule
